[hdl/expression_token_lexer_macros.svh]
// assertion macros for the expression token lexer
`ifndef EXPRESSION_TOKEN_LEXER_MACROS_SVH
`define EXPRESSION_TOKEN_LEXER_MACROS_SVH
`ifndef SYNTHESIS
`define ETL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ETL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ETL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ETL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/etl_pkg.sv]
// types and constants shared by the expression token lexer
package etl_pkg;

	localparam int POSITION_BITS_DEF = 16;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_NUM  = 2'd1;
	localparam logic [1:0] MODE_NAME = 2'd2;
	localparam logic [1:0] MODE_STR  = 2'd3;

	localparam logic [3:0] K_PLUS     = 4'd0;
	localparam logic [3:0] K_STAR     = 4'd1;
	localparam logic [3:0] K_LPAREN   = 4'd2;
	localparam logic [3:0] K_RPAREN   = 4'd3;
	localparam logic [3:0] K_LBRACKET = 4'd4;
	localparam logic [3:0] K_RBRACKET = 4'd5;
	localparam logic [3:0] K_DOT      = 4'd6;
	localparam logic [3:0] K_NUMBER   = 4'd7;
	localparam logic [3:0] K_NAME     = 4'd8;
	localparam logic [3:0] K_STRING   = 4'd9;
	localparam logic [3:0] K_EOF      = 4'd10;
	localparam logic [3:0] K_MISSQ    = 4'd11;
	localparam logic [3:0] K_BAD      = 4'd12;

	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_SQUOTE   = 8'h27;
	localparam logic [7:0] CH_DQUOTE   = 8'h22;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_text;
	} char_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_of_run;
	} token_t;

endpackage

[hdl/expression_token_lexer.sv]
// expression token lexer: one character per transaction in, tokens out
// a token passes through the input register and then the queue before it leaves
// throughput: one character per cycle; ending a run with a symbol, a bad character or end of text
//   gives two token transactions, and the input stalls while the four-entry queue holds more than two
// the scan mode, position and pending start live in one register each, updated once per character
// reset: asynchronous, active low; clears mode, position, pending start, input valid and queue
`include "expression_token_lexer_macros.svh"

module expression_token_lexer #(
	parameter int POSITION_BITS = etl_pkg::POSITION_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           char_valid,
	output logic           char_stall,
	input  etl_pkg::char_t char_data,
	output logic           token_valid,
	input  logic           token_stall,
	output etl_pkg::token_t token_data
);
	import etl_pkg::*;

	localparam int PB = POSITION_BITS;

	logic          valid_s1;
	char_t         data_s1;
	logic [1:0]    mode_q;
	logic [PB-1:0] pos_q;
	logic [PB-1:0] start_q;

	token_t        queue_q [4];
	logic [1:0]    wp_q;
	logic [1:0]    rp_q;
	logic [2:0]    cnt_q;

	logic          adv;
	logic          pop;
	logic [1:0]    mode_d;
	logic [PB-1:0] pos_d;
	logic [PB-1:0] start_d;
	logic          flush_v;
	logic          sec_v;
	token_t        flush_tok;
	token_t        sec_tok;
	token_t        slot_a;
	token_t        slot_b;
	logic [1:0]    push_n;

	logic [7:0]    c;
	logic          is_digit;
	logic          is_alpha;
	logic          is_quote;
	logic [PB-1:0] pos_inc;
	logic [PB-1:0] len_full;
	logic [PB+15:0] pos_ext;
	logic [PB+15:0] start_ext;
	logic [PB+15:0] len_ext;
	logic [15:0]   pos16;
	logic [15:0]   start16;
	logic [15:0]   len16;
	logic [3:0]    flush_kind;

	assign adv        = valid_s1 && (cnt_q <= 3'd2);
	assign char_stall = valid_s1 && !adv;
	assign pop        = token_valid && !token_stall;
	assign token_valid = (cnt_q != 3'd0);
	assign token_data  = queue_q[rp_q];

	assign c        = data_s1.character;
	assign is_digit = c inside {[8'h30:8'h39]};
	assign is_alpha = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	assign is_quote = (c == CH_SQUOTE) || (c == CH_DQUOTE);
	assign pos_inc  = (pos_q == {PB{1'b1}}) ? pos_q : pos_q + 1'b1;
	assign len_full = (pos_q >= start_q) ? pos_q - start_q : '0;

	assign pos_ext   = {16'b0, pos_q};
	assign start_ext = {16'b0, start_q};
	assign len_ext   = {16'b0, len_full};
	assign pos16     = pos_ext[15:0];
	assign start16   = start_ext[15:0];
	assign len16     = len_ext[15:0];

	always_comb begin
		case (mode_q)
			MODE_NUM:  flush_kind = K_NUMBER;
			MODE_NAME: flush_kind = K_NAME;
			MODE_STR:  flush_kind = K_MISSQ;
			default:   flush_kind = K_NUMBER;
		endcase
	end

	always_comb begin
		flush_v   = 1'b0;
		sec_v     = 1'b0;
		flush_tok = '{token_kind: flush_kind, token_start: start16, token_length: len16,
			last_of_run: 1'b0};
		sec_tok   = '{token_kind: K_BAD, token_start: pos16, token_length: 16'd1,
			last_of_run: 1'b1};
		mode_d    = mode_q;
		pos_d     = pos_q;
		start_d   = start_q;
		if (data_s1.end_of_text) begin
			flush_v = (mode_q != MODE_IDLE);
			sec_v   = 1'b1;
			sec_tok.token_kind   = K_EOF;
			sec_tok.token_length = 16'd0;
			mode_d  = MODE_IDLE;
			pos_d   = '0;
			start_d = '0;
		end else if (mode_q == MODE_NUM && is_digit) begin
			pos_d = pos_inc;
		end else if ((mode_q == MODE_NAME || mode_q == MODE_STR) && (is_digit || is_alpha)) begin
			pos_d = pos_inc;
		end else if (mode_q == MODE_STR && is_quote) begin
			sec_v = 1'b1;
			sec_tok.token_kind   = K_STRING;
			sec_tok.token_start  = start16;
			sec_tok.token_length = len16;
			mode_d = MODE_IDLE;
			pos_d  = pos_inc;
		end else begin
			flush_v = (mode_q != MODE_IDLE);
			mode_d  = MODE_IDLE;
			pos_d   = pos_inc;
			sec_v   = 1'b1;
			case (c)
				CH_SPACE:    sec_v = 1'b0;
				CH_PLUS:     sec_tok.token_kind = K_PLUS;
				CH_STAR:     sec_tok.token_kind = K_STAR;
				CH_LPAREN:   sec_tok.token_kind = K_LPAREN;
				CH_RPAREN:   sec_tok.token_kind = K_RPAREN;
				CH_LBRACKET: sec_tok.token_kind = K_LBRACKET;
				CH_RBRACKET: sec_tok.token_kind = K_RBRACKET;
				CH_DOT:      sec_tok.token_kind = K_DOT;
				default: begin
					if (is_digit) begin
						sec_v   = 1'b0;
						mode_d  = MODE_NUM;
						start_d = pos_q;
					end else if (is_alpha) begin
						sec_v   = 1'b0;
						mode_d  = MODE_NAME;
						start_d = pos_q;
					end else if (is_quote) begin
						sec_v   = 1'b0;
						mode_d  = MODE_STR;
						start_d = pos_inc;
					end
				end
			endcase
		end
	end

	always_comb begin
		slot_a = flush_v ? flush_tok : sec_tok;
		slot_a.last_of_run = !(flush_v && sec_v);
		slot_b = sec_tok;
		push_n = {1'b0, flush_v} + {1'b0, sec_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			data_s1 <= char_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
		end else if (adv) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push_n != 2'd0) begin
			queue_q[wp_q] <= slot_a;
		end
		if (adv && push_n == 2'd2) begin
			queue_q[wp_q + 2'd1] <= slot_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (adv) begin
				wp_q <= wp_q + push_n;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, (adv ? push_n : 2'd0)} - {2'b0, pop};
		end
	end

	`ETL_ASSERT_IMPL(a_queue_bound, clk, arst_n, 1'b1, cnt_q <= 3'd4)
	`ETL_ASSERT_NEXT(a_eot_clears, clk, arst_n, adv && data_s1.end_of_text, pos_q == '0 && mode_q == MODE_IDLE)
	`ETL_ASSERT_IMPL(a_start_order, clk, arst_n, mode_q != MODE_IDLE, start_q <= pos_q)

endmodule

[dv/expression_token_lexer_tb.sv]
// testbench for the expression token lexer: directed and random text checked against a token predictor
module expression_token_lexer_tb;
	import etl_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int LONG_TEXT    = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 150;
	localparam int N_DIRECTED   = 28;

	typedef struct packed {
		logic [7:0]  ch;
		logic        eot;
		logic        typed;
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
	} stim_row_t;

	logic   clk;
	logic   arst_n;
	logic   char_valid;
	logic   char_stall;
	char_t  char_data;
	logic   token_valid;
	logic   token_stall;
	token_t token_data;

	token_t      tokens_due[$];
	token_t      step_tokens[$];
	logic [1:0]  scan_state = MODE_IDLE;
	logic [15:0] scan_pos = '0;
	logic [15:0] tok_begin = '0;
	int          failures = 0;
	int          items_sent = 0;
	int          tokens_seen = 0;
	int          idle_cycles = 0;
	int          stall_left = 0;
	bit          tx_gaps_on = 1'b1;
	bit          rx_stalls_on = 1'b1;
	bit          pressure_done = 1'b0;

	stim_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{CH_PLUS,     1'b0, 1'b1, K_PLUS,     16'd0,  16'd1},
		'{CH_STAR,     1'b0, 1'b1, K_STAR,     16'd1,  16'd1},
		'{CH_LPAREN,   1'b0, 1'b1, K_LPAREN,   16'd2,  16'd1},
		'{CH_RPAREN,   1'b0, 1'b1, K_RPAREN,   16'd3,  16'd1},
		'{CH_LBRACKET, 1'b0, 1'b1, K_LBRACKET, 16'd4,  16'd1},
		'{CH_RBRACKET, 1'b0, 1'b1, K_RBRACKET, 16'd5,  16'd1},
		'{CH_DOT,      1'b0, 1'b1, K_DOT,      16'd6,  16'd1},
		'{CH_SPACE,    1'b0, 1'b0, '0,         '0,     '0},
		'{8'h00,       1'b0, 1'b1, K_BAD,      16'd8,  16'd1},
		'{8'hFF,       1'b0, 1'b1, K_BAD,      16'd9,  16'd1},
		'{"0",         1'b0, 1'b0, '0,         '0,     '0},
		'{"9",         1'b0, 1'b0, '0,         '0,     '0},
		'{"a",         1'b0, 1'b0, '0,         '0,     '0},
		'{"Z",         1'b0, 1'b0, '0,         '0,     '0},
		'{"z",         1'b0, 1'b0, '0,         '0,     '0},
		'{"A",         1'b0, 1'b0, '0,         '0,     '0},
		'{CH_SQUOTE,   1'b0, 1'b0, '0,         '0,     '0},
		'{"7",         1'b0, 1'b0, '0,         '0,     '0},
		'{"q",         1'b0, 1'b0, '0,         '0,     '0},
		'{CH_DQUOTE,   1'b0, 1'b0, '0,         '0,     '0},
		'{CH_DQUOTE,   1'b0, 1'b0, '0,         '0,     '0},
		'{"x",         1'b0, 1'b0, '0,         '0,     '0},
		'{"$",         1'b0, 1'b0, '0,         '0,     '0},
		'{CH_SQUOTE,   1'b0, 1'b0, '0,         '0,     '0},
		'{"k",         1'b0, 1'b0, '0,         '0,     '0},
		'{8'hA5,       1'b1, 1'b0, '0,         '0,     '0},
		'{8'h00,       1'b1, 1'b1, K_EOF,      16'd0,  16'd0},
		'{CH_PLUS,     1'b0, 1'b1, K_PLUS,     16'd0,  16'd1}
	};

	expression_token_lexer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_data (token_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_quote(logic [7:0] c);
		return c == CH_SQUOTE || c == CH_DQUOTE;
	endfunction

	function automatic logic [15:0] sat_next(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [15:0] run_len();
		return (scan_pos >= tok_begin) ? scan_pos - tok_begin : 16'd0;
	endfunction

	function automatic void emit(logic [3:0] kind, logic [15:0] start, logic [15:0] len);
		token_t t;
		t.token_kind   = kind;
		t.token_start  = start;
		t.token_length = len;
		t.last_of_run  = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void flush_run();
		case (scan_state)
			MODE_NUM: emit(K_NUMBER, tok_begin, run_len());
			MODE_NAME: emit(K_NAME, tok_begin, run_len());
			MODE_STR: emit(K_MISSQ, tok_begin, run_len());
			default: ;
		endcase
		scan_state = MODE_IDLE;
	endfunction

	function automatic void start_fresh(logic [7:0] c);
		logic [3:0] kind;
		bit         hit;
		hit  = 1'b1;
		kind = K_BAD;
		case (c)
			CH_SPACE: hit = 1'b0;
			CH_PLUS: kind = K_PLUS;
			CH_STAR: kind = K_STAR;
			CH_LPAREN: kind = K_LPAREN;
			CH_RPAREN: kind = K_RPAREN;
			CH_LBRACKET: kind = K_LBRACKET;
			CH_RBRACKET: kind = K_RBRACKET;
			CH_DOT: kind = K_DOT;
			default: begin
				if (is_digit(c)) begin
					hit = 1'b0;
					scan_state = MODE_NUM;
					tok_begin = scan_pos;
				end else if (is_alpha(c)) begin
					hit = 1'b0;
					scan_state = MODE_NAME;
					tok_begin = scan_pos;
				end else if (is_quote(c)) begin
					hit = 1'b0;
					scan_state = MODE_STR;
					tok_begin = sat_next(scan_pos);
				end
			end
		endcase
		if (hit)
			emit(kind, scan_pos, 16'd1);
		scan_pos = sat_next(scan_pos);
	endfunction

	// tokens caused by one character transaction, left in step_tokens
	function automatic void lex_character(char_t c);
		token_t t;
		step_tokens.delete();
		if (c.end_of_text) begin
			flush_run();
			emit(K_EOF, scan_pos, 16'd0);
			scan_state = MODE_IDLE;
			scan_pos = '0;
			tok_begin = '0;
		end else if (scan_state == MODE_NUM && is_digit(c.character)) begin
			scan_pos = sat_next(scan_pos);
		end else if ((scan_state == MODE_NAME || scan_state == MODE_STR) &&
				(is_digit(c.character) || is_alpha(c.character))) begin
			scan_pos = sat_next(scan_pos);
		end else if (scan_state == MODE_STR && is_quote(c.character)) begin
			emit(K_STRING, tok_begin, run_len());
			scan_state = MODE_IDLE;
			scan_pos = sat_next(scan_pos);
		end else begin
			flush_run();
			start_fresh(c.character);
		end
		if (step_tokens.size() > 0) begin
			t = step_tokens.pop_back();
			t.last_of_run = 1'b1;
			step_tokens.push_back(t);
		end
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 16)
			return $urandom_range(1, 3);
		else if (r < 19)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic char_t mk_char(logic [7:0] b, logic e);
		char_t c;
		c.character   = b;
		c.end_of_text = e;
		return c;
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'h41 + 8'($urandom_range(0, 25));
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_alnum();
		return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
	endfunction

	function automatic logic [7:0] rand_quote();
		return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
	endfunction

	function automatic logic [7:0] rand_symbol();
		case ($urandom_range(0, 6))
			0: return CH_PLUS;
			1: return CH_STAR;
			2: return CH_LPAREN;
			3: return CH_RPAREN;
			4: return CH_LBRACKET;
			5: return CH_RBRACKET;
			default: return CH_DOT;
		endcase
	endfunction

	task automatic send_char(input char_t c, input bit typed, input token_t typed_tok);
		int gap;
		gap = 0;
		if (tx_gaps_on && $urandom_range(0, 2) == 0)
			gap = gap_length();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= c;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		lex_character(c);
		if (typed)
			tokens_due.push_back(typed_tok);
		else
			foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
		items_sent++;
		if ($urandom_range(0, 99) == 0)
			tx_gaps_on = !tx_gaps_on;
	endtask

	task automatic send_plain(input logic [7:0] b);
		send_char(mk_char(b, 1'b0), 1'b0, '0);
	endtask

	// one lexeme, mostly well formed, sometimes broken or noise
	task automatic send_lexeme();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			n = $urandom_range(1, 5);
			repeat (n) send_plain(rand_digit());
		end else if (pick < 40) begin
			send_plain(rand_letter());
			n = $urandom_range(0, 5);
			repeat (n) send_plain(rand_alnum());
		end else if (pick < 55) begin
			send_plain(rand_quote());
			n = $urandom_range(0, 5);
			repeat (n) send_plain(rand_alnum());
			send_plain(rand_quote());
		end else if (pick < 75) begin
			send_plain(rand_symbol());
		end else if (pick < 85) begin
			n = $urandom_range(1, 3);
			repeat (n) send_plain(CH_SPACE);
		end else if (pick < 90) begin
			// unterminated string
			send_plain(rand_quote());
			n = $urandom_range(0, 4);
			repeat (n) send_plain(rand_alnum());
			if ($urandom_range(0, 2) == 0)
				send_char(mk_char(8'($urandom_range(0, 255)), 1'b1), 1'b0, '0);
			else if ($urandom_range(0, 1))
				send_plain(8'($urandom_range(128, 255)));
			else
				send_plain(8'($urandom_range(0, 31)));
		end else if (pick < 96) begin
			send_plain(8'($urandom_range(0, 255)));
		end else begin
			send_char(mk_char(8'($urandom_range(0, 255)), 1'b1), 1'b0, '0);
		end
	endtask

	initial begin
		token_t t;
		arst_n     <= 1'b0;
		char_valid <= 1'b0;
		char_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			t.token_kind   = directed_rows[i].kind;
			t.token_start  = directed_rows[i].start;
			t.token_length = directed_rows[i].len;
			t.last_of_run  = 1'b1;
			send_char(mk_char(directed_rows[i].ch, directed_rows[i].eot),
				directed_rows[i].typed, t);
		end

		while (items_sent < RANDOM_ITEMS)
			send_lexeme();
		send_char(mk_char(8'($urandom_range(0, 255)), 1'b1), 1'b0, '0);

		// long name, closed string and a number flushed by end of text
		send_plain("a");
		repeat (LONG_TEXT) send_plain(rand_alnum());
		send_plain(CH_SPACE);
		send_plain(CH_PLUS);
		send_plain(CH_SQUOTE);
		send_plain("b");
		send_plain(CH_DQUOTE);
		send_plain("5");
		send_char(mk_char(8'h5A, 1'b1), 1'b0, '0);
		char_valid <= 1'b0;

		while (tokens_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// receiver stalls, with one long hold-off to back up the block
	initial begin
		token_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!pressure_done && tokens_seen >= HOLD_AFTER) begin
				pressure_done = 1'b1;
				token_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (stall_left > 0)
				stall_left--;
			else if (rx_stalls_on && $urandom_range(0, 3) == 0)
				stall_left = gap_length();
			if ($urandom_range(0, 149) == 0)
				rx_stalls_on = !rx_stalls_on;
			token_stall <= (stall_left > 0);
		end
	end

	always @(posedge clk) begin
		token_t want;
		if (arst_n && token_valid && !token_stall) begin
			tokens_seen++;
			if (tokens_due.size() == 0) begin
				failures++;
				$error("token with no expectation: kind %0d start %0d length %0d",
					token_data.token_kind, token_data.token_start, token_data.token_length);
			end else begin
				want = tokens_due.pop_front();
				if (token_data.token_kind !== want.token_kind) begin
					failures++;
					$error("token_kind: expected %0d, got %0d",
						want.token_kind, token_data.token_kind);
				end
				if (token_data.token_start !== want.token_start) begin
					failures++;
					$error("token_start: expected %0d, got %0d",
						want.token_start, token_data.token_start);
				end
				if (token_data.token_length !== want.token_length) begin
					failures++;
					$error("token_length: expected %0d, got %0d",
						want.token_length, token_data.token_length);
				end
				if (token_data.last_of_run !== want.last_of_run) begin
					failures++;
					$error("last_of_run: expected %0d, got %0d",
						want.last_of_run, token_data.last_of_run);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (token_valid && !token_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
